### hw/rtl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// shared types and constants of the five voice chiptune synth
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam int FIFO_DEPTH_DEF = 8;
    localparam int NUM_VOICES     = 5;
    localparam int VOICE_W        = 3;

    // voice codes
    localparam logic [VOICE_W-1:0] VOICE_PULSE_A = 3'd0;
    localparam logic [VOICE_W-1:0] VOICE_PULSE_B = 3'd1;
    localparam logic [VOICE_W-1:0] VOICE_TRI     = 3'd2;
    localparam logic [VOICE_W-1:0] VOICE_SAW     = 3'd3;
    localparam logic [VOICE_W-1:0] VOICE_NOISE   = 3'd4;

    // command codes
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    // divider iteration counts
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] RAMP_BITS = 6'd16;
    localparam logic [DIV_CNT_W-1:0] MOD_BITS  = 6'd33;

    typedef struct packed {
        logic [15:0] volume;
        logic [23:0] release_n;
        logic [23:0] attack;
        logic [23:0] length;
        logic [31:0] sweep;
        logic [23:0] step;
    } t_note;

    typedef struct packed {
        logic                 start;
        logic [31:0]          rem_init;
        logic [32:0]          num;
        logic [31:0]          divisor;
        logic [DIV_CNT_W-1:0] count;
    } t_div_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK,
        ST_LOAD_RD,
        ST_LOAD_WR,
        ST_ATK,
        ST_ATK_WAIT,
        ST_REL,
        ST_REL_WAIT,
        ST_G1,
        ST_G2,
        ST_WAVE,
        ST_NDIV_WAIT,
        ST_LFSR,
        ST_NMUL,
        ST_NLAT,
        ST_ACC
    } t_state;

endpackage

### hw/rtl/cts_note_mem.sv
// ----------------------------------------------------------------------------
// cts_note_mem
// note store for all voice queues, one write and one registered read port
// ----------------------------------------------------------------------------
module cts_note_mem #(
    parameter int ENTRIES = 40,
    parameter int AW      = 6
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  cts_pkg::t_note  i_wr_data,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output cts_pkg::t_note  o_rd_data
);
    import cts_pkg::*;

    t_note r_mem [ENTRIES];
    t_note r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/cts_div.sv
// ----------------------------------------------------------------------------
// cts_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module cts_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cts_pkg::t_div_req i_req,
    output logic              o_busy,
    output logic [15:0]       o_quo,
    output logic [31:0]       o_rem
);
    import cts_pkg::*;

    logic                 r_busy;
    logic [32:0]          r_rem;
    logic [32:0]          r_num;
    logic [31:0]          r_div;
    logic [15:0]          r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [32:0]          trial;
    logic                 ge;

    assign trial = {r_rem[31:0], r_num[32]};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == DIV_CNT_W'(1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {1'b0, i_req.rem_init};
            r_num <= i_req.num;
            r_div <= i_req.divisor;
            r_quo <= '0;
            r_cnt <= i_req.count;
        end else if (r_busy) begin
            r_rem <= ge ? trial - {1'b0, r_div} : trial;
            r_num <= {r_num[31:0], 1'b0};
            r_quo <= {r_quo[14:0], ge};
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[31:0];

endmodule

### hw/rtl/five_voice_chiptune_synth_unit.sv
// ----------------------------------------------------------------------------
// five_voice_chiptune_synth_unit
// five voice sound generator: two pulses, triangle, sawtooth, noise
// ----------------------------------------------------------------------------
// usage
// - input beats on s_axis: tuser[0] is the command. an enqueue beat appends a
//   note to the queue of its voice; a tick beat makes one mixed sample
// - every input beat yields exactly one output beat on m_axis: the sample for
//   a tick, or a zero sample with the drop flag for an enqueue
// - an enqueue is handled in the idle state. a tick walks the five voices
//   one after the other through one shared divider and one shared
//   multiplier; a playing voice takes more steps than a silent one, and a
//   note load, each ramp division that is needed, and for the noise voice
//   the period modulo and the drawing of a new level add further steps
// - s_axis_tready is low while a tick is worked on and while an output beat
//   waits; a stalled receiver holds the output beat and blocks new input
// - reset clears the queues, voice phases and the noise generator; the note
//   store itself needs no clearing
// ----------------------------------------------------------------------------
module five_voice_chiptune_synth_unit #(
    parameter int FIFO_DEPTH = cts_pkg::FIFO_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // voice[2:0], phase_step[26:3], sweep_step[58:27], length_samples[82:59],
    // attack_samples[106:83], release_samples[130:107], volume[146:131]
    input  logic [151:0] s_axis_tdata,
    // command[0]
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // mixed_sample[18:0]
    output logic [23:0]  m_axis_tdata,
    // sample_valid[0], enqueue_dropped[1]
    output logic [1:0]   m_axis_tuser
);
    import cts_pkg::*;

    localparam int ENTRIES = NUM_VOICES * FIFO_DEPTH;
    localparam int AW      = $clog2(ENTRIES);
    localparam int PW      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FW      = $clog2(FIFO_DEPTH + 1);

    // where the per-voice check stands
    localparam logic [1:0] CHK_FIRST      = 2'd0;
    localparam logic [1:0] CHK_AFTER_IDLE = 2'd1;
    localparam logic [1:0] CHK_LOADED     = 2'd2;

    t_state r_state, n_state;

    // per voice queue control and current note
    logic          r_busy     [NUM_VOICES];
    logic [FW-1:0] r_fill     [NUM_VOICES];
    logic [PW-1:0] r_rptr     [NUM_VOICES];
    logic [PW-1:0] r_wptr     [NUM_VOICES];
    logic [31:0]   r_cur_step [NUM_VOICES];
    logic [31:0]   r_cur_sweep[NUM_VOICES];
    logic [23:0]   r_cur_rem  [NUM_VOICES];
    logic [23:0]   r_cur_len  [NUM_VOICES];
    logic [23:0]   r_cur_atk  [NUM_VOICES];
    logic [23:0]   r_cur_rel  [NUM_VOICES];
    logic [15:0]   r_cur_vol  [NUM_VOICES];
    logic [31:0]   r_phase    [NUM_VOICES];

    logic signed [16:0] r_nlevel;
    logic [22:0]        r_lfsr;

    // tick sequencer
    logic [VOICE_W-1:0] r_v;
    logic [1:0]         r_chk;
    logic [3:0]         r_cnt;
    logic signed [18:0] r_mix;
    logic [16:0]        r_a;
    logic [16:0]        r_r;
    logic [15:0]        r_g;
    logic signed [35:0] r_prod;

    // output beat
    logic        r_out_valid;
    logic [18:0] r_out_sample;
    logic        r_out_sv;
    logic        r_out_drop;

    // input fields
    logic               in_cmd;
    logic [VOICE_W-1:0] in_voice;
    t_note              in_note;
    logic               s_accept;
    logic               in_vok;
    logic [VOICE_W-1:0] vsel;
    logic               in_full;
    logic               enq_wr;

    assign in_cmd            = s_axis_tuser[0];
    assign in_voice          = s_axis_tdata[2:0];
    assign in_note.step      = s_axis_tdata[26:3];
    assign in_note.sweep     = s_axis_tdata[58:27];
    assign in_note.length    = s_axis_tdata[82:59];
    assign in_note.attack    = s_axis_tdata[106:83];
    assign in_note.release_n = s_axis_tdata[130:107];
    assign in_note.volume    = s_axis_tdata[146:131];

    assign s_axis_tready = (r_state == ST_IDLE) && !r_out_valid;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign in_vok        = in_voice < VOICE_W'(NUM_VOICES);
    assign vsel          = in_vok ? in_voice : VOICE_PULSE_A;
    assign in_full       = r_fill[vsel] == FW'(FIFO_DEPTH);
    assign enq_wr        = s_accept && (in_cmd == CMD_ENQUEUE) && in_vok && !in_full;

    // current voice view
    logic [31:0] c_step, c_sweep, c_phase;
    logic [23:0] c_rem, c_len, c_atk, c_rel, elapsed;
    logic [15:0] c_vol;
    logic [FW-1:0] c_fill;
    logic        c_busy, last_voice, is_noise;

    assign c_step     = r_cur_step[r_v];
    assign c_sweep    = r_cur_sweep[r_v];
    assign c_phase    = r_phase[r_v];
    assign c_rem      = r_cur_rem[r_v];
    assign c_len      = r_cur_len[r_v];
    assign c_atk      = r_cur_atk[r_v];
    assign c_rel      = r_cur_rel[r_v];
    assign c_vol      = r_cur_vol[r_v];
    assign c_fill     = r_fill[r_v];
    assign c_busy     = r_busy[r_v];
    assign elapsed    = c_len - c_rem;
    assign last_voice = r_v == VOICE_NOISE;
    assign is_noise   = r_v == VOICE_NOISE;

    logic atk_full, rel_full;
    assign atk_full = (c_atk == 24'd0) || (elapsed >= c_atk);
    assign rel_full = !(c_rem < c_rel);

    // note store
    logic [AW-1:0] wr_addr, rd_addr;
    t_note         rd_note;
    logic          mem_rd;

    assign wr_addr = AW'(vsel) * AW'(FIFO_DEPTH) + AW'(r_wptr[vsel]);
    assign rd_addr = AW'(r_v) * AW'(FIFO_DEPTH) + AW'(r_rptr[r_v]);

    cts_note_mem #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (enq_wr),
        .i_wr_addr (wr_addr),
        .i_wr_data (in_note),
        .i_rd_en   (mem_rd),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_note)
    );

    // shared divider
    t_div_req    div_req;
    logic        div_busy;
    logic [15:0] div_quo;
    logic [31:0] div_rem;

    cts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_busy  (div_busy),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // waveform of the tone voices
    logic [31:0]        tri_d;
    logic [31:0]        saw_d;
    logic signed [17:0] w_tone;
    logic [15:0]        g_now;

    assign tri_d = c_phase[31] ? c_phase - 32'h8000_0000 : 32'h8000_0000 - c_phase;
    assign saw_d = c_phase - 32'h8000_0000;
    assign g_now = r_prod[31:16];

    always_comb begin
        case (r_v) inside
            VOICE_PULSE_A, VOICE_PULSE_B: begin
                w_tone = (c_phase <= 32'h2000_0000) ? 18'sd32768 : -18'sd32768;
            end
            VOICE_TRI: w_tone = 18'sd32768 - $signed({1'b0, tri_d[31:15]});
            default:   w_tone = $signed({2'b00, saw_d[31:16]}) - 18'sd32768;
        endcase
    end

    // shared multiplier operands
    logic               mul_en;
    logic signed [17:0] mul_a, mul_b;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept && in_cmd == CMD_TICK) n_state = ST_CHK;
            end
            ST_CHK: begin
                if (r_chk == CHK_LOADED) begin
                    n_state = ST_ATK;
                end else if (!c_busy) begin
                    n_state = (c_fill == '0) ? ST_ACC : ST_LOAD_RD;
                end else if (c_rem == 24'd0) begin
                    n_state = (c_fill != '0) ? ST_LOAD_RD : ST_ACC;
                end else begin
                    n_state = ST_ATK;
                end
            end
            ST_LOAD_RD:  n_state = ST_LOAD_WR;
            ST_LOAD_WR:  n_state = ST_CHK;
            ST_ATK:      n_state = atk_full ? ST_REL : ST_ATK_WAIT;
            ST_ATK_WAIT: if (!div_busy) n_state = ST_REL;
            ST_REL:      n_state = rel_full ? ST_G1 : ST_REL_WAIT;
            ST_REL_WAIT: if (!div_busy) n_state = ST_G1;
            ST_G1:       n_state = ST_G2;
            ST_G2:       n_state = ST_WAVE;
            ST_WAVE: begin
                n_state = (is_noise && c_step != 32'd0) ? ST_NDIV_WAIT : ST_ACC;
            end
            ST_NDIV_WAIT: begin
                if (!div_busy) n_state = (c_phase > div_rem) ? ST_LFSR : ST_ACC;
            end
            ST_LFSR:     if (r_cnt == 4'd15) n_state = ST_NMUL;
            ST_NMUL:     n_state = ST_NLAT;
            ST_NLAT:     n_state = ST_ACC;
            ST_ACC:      n_state = last_voice ? ST_IDLE : ST_CHK;
            default:     n_state = ST_IDLE;
        endcase
    end

    // control outputs of the sequencer
    always_comb begin
        mem_rd           = 1'b0;
        div_req.start    = 1'b0;
        div_req.rem_init = {8'd0, elapsed};
        div_req.num      = '0;
        div_req.divisor  = {8'd0, c_atk};
        div_req.count    = RAMP_BITS;
        mul_en           = 1'b0;
        mul_a            = $signed({2'b00, c_vol});
        mul_b            = $signed({1'b0, r_a});
        unique case (r_state)
            ST_LOAD_RD: mem_rd = 1'b1;
            ST_ATK: div_req.start = !atk_full;
            ST_REL: begin
                div_req.start    = !rel_full;
                div_req.rem_init = {8'd0, c_rem};
                div_req.divisor  = {8'd0, c_rel};
            end
            ST_G1: mul_en = 1'b1;
            ST_G2: begin
                mul_en = 1'b1;
                mul_a  = $signed({2'b00, g_now});
                mul_b  = $signed({1'b0, r_r});
            end
            ST_WAVE: begin
                // noise: modulo of the advanced phase by the hold period
                div_req.start    = is_noise && c_step != 32'd0;
                div_req.rem_init = '0;
                div_req.num      = {1'b0, c_phase} + 33'h1_0000;
                div_req.divisor  = c_step;
                div_req.count    = MOD_BITS;
                mul_en           = !is_noise;
                mul_a            = w_tone;
                mul_b            = $signed({2'b00, g_now});
            end
            ST_NMUL: begin
                mul_en = 1'b1;
                mul_a  = $signed({{2{~r_lfsr[15]}}, ~r_lfsr[15], r_lfsr[14:0]});
                mul_b  = $signed({2'b00, r_g});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // swept step, saturating at zero and full scale
    logic signed [33:0] sweep_sum;
    logic [31:0]        step_next;
    assign sweep_sum = $signed({2'b00, c_step}) + $signed({{2{c_sweep[31]}}, c_sweep});
    assign step_next = sweep_sum[33] ? 32'd0 :
                       sweep_sum[32] ? 32'hFFFF_FFFF : sweep_sum[31:0];

    logic active;
    assign active = (r_chk == CHK_LOADED) || (c_busy && c_rem != 24'd0);

    logic [PW-1:0] rptr_next, wptr_next;
    assign rptr_next = (r_rptr[r_v] == PW'(FIFO_DEPTH - 1)) ? '0 : r_rptr[r_v] + PW'(1);
    assign wptr_next = (r_wptr[vsel] == PW'(FIFO_DEPTH - 1)) ? '0 : r_wptr[vsel] + PW'(1);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_VOICES; i++) begin
                r_busy[i]  <= 1'b0;
                r_fill[i]  <= '0;
                r_rptr[i]  <= '0;
                r_wptr[i]  <= '0;
                r_phase[i] <= '0;
            end
            r_nlevel    <= '0;
            r_lfsr      <= 23'd1;
            r_out_valid <= 1'b0;
            r_v         <= '0;
            r_chk       <= CHK_FIRST;
            r_cnt       <= '0;
        end else begin
            if (r_out_valid && m_axis_tready) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    r_v   <= VOICE_PULSE_A;
                    r_chk <= CHK_FIRST;
                    if (s_accept && in_cmd == CMD_ENQUEUE) begin
                        r_out_valid <= 1'b1;
                    end
                    if (enq_wr) begin
                        r_wptr[vsel] <= wptr_next;
                        r_fill[vsel] <= r_fill[vsel] + FW'(1);
                    end
                end
                ST_CHK: begin
                    if (r_chk != CHK_LOADED) begin
                        if (!c_busy) begin
                            r_chk <= CHK_AFTER_IDLE;
                        end else if (c_rem == 24'd0) begin
                            // ended note: load the successor or go silent
                            if (c_fill == '0) r_busy[r_v] <= 1'b0;
                            else r_chk <= CHK_LOADED;
                        end
                    end
                end
                ST_LOAD_WR: begin
                    r_busy[r_v] <= 1'b1;
                    r_rptr[r_v] <= rptr_next;
                    r_fill[r_v] <= c_fill - FW'(1);
                end
                ST_WAVE: begin
                    if (is_noise && c_step == 32'd0) r_phase[r_v] <= '0;
                end
                ST_NDIV_WAIT: begin
                    r_cnt <= '0;
                    if (!div_busy) r_phase[r_v] <= div_rem;
                end
                ST_LFSR: begin
                    r_lfsr <= {r_lfsr[21:0], r_lfsr[22] ^ r_lfsr[17]};
                    r_cnt  <= r_cnt + 4'd1;
                end
                ST_NLAT: r_nlevel <= r_prod[32:16];
                ST_ACC: begin
                    if (active && !is_noise) r_phase[r_v] <= c_phase + c_step;
                    r_v   <= r_v + VOICE_W'(1);
                    r_chk <= CHK_FIRST;
                    if (last_voice) r_out_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (mul_en) r_prod <= mul_a * mul_b;
        if (enq_wr || r_state != ST_IDLE || s_accept) begin
            // held below by state only
        end
        unique case (r_state)
            ST_IDLE: begin
                r_mix <= '0;
                if (s_accept && in_cmd == CMD_ENQUEUE) begin
                    r_out_sample <= '0;
                    r_out_sv     <= 1'b0;
                    r_out_drop   <= in_vok && in_full;
                end
            end
            ST_LOAD_WR: begin
                r_cur_step[r_v]  <= {rd_note.step, 8'd0};
                r_cur_sweep[r_v] <= rd_note.sweep;
                r_cur_len[r_v]   <= rd_note.length;
                r_cur_rem[r_v]   <= rd_note.length;
                r_cur_atk[r_v]   <= rd_note.attack;
                r_cur_rel[r_v]   <= rd_note.release_n;
                r_cur_vol[r_v]   <= rd_note.volume;
            end
            ST_ATK:      r_a <= 17'h1_0000;
            ST_ATK_WAIT: r_a <= {1'b0, div_quo};
            ST_REL:      r_r <= 17'h1_0000;
            ST_REL_WAIT: r_r <= {1'b0, div_quo};
            ST_WAVE:     r_g <= g_now;
            ST_ACC: begin
                if (active) begin
                    r_mix <= is_noise ? r_mix + {{2{r_nlevel[16]}}, r_nlevel}
                                      : r_mix + r_prod[34:16];
                    if (c_rem != 24'd0) r_cur_rem[r_v] <= c_rem - 24'd1;
                    r_cur_step[r_v] <= step_next;
                end
                if (last_voice) begin
                    r_out_sample <= active
                        ? (is_noise ? r_mix + {{2{r_nlevel[16]}}, r_nlevel}
                                    : r_mix + r_prod[34:16])
                        : r_mix;
                    r_out_sv     <= 1'b1;
                    r_out_drop   <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_sample};
    assign m_axis_tuser  = {r_out_drop, r_out_sv};

endmodule

### tb/five_voice_chiptune_synth_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_voice_chiptune_synth_unit_test
// self-checking bench for the five voice chiptune synth
// ----------------------------------------------------------------------------
// drives enqueue and tick beats with random gaps and output stalls, predicts
// each output beat with a behavioral model of the voices, and compares the
// beats field by field in order
// ----------------------------------------------------------------------------
module five_voice_chiptune_synth_unit_test;
    import cts_pkg::*;

    localparam int DEPTH = FIFO_DEPTH_DEF;

    typedef struct packed {
        logic [18:0] sample;
        logic        tick;
        logic        dropped;
    } t_beat_out;

    // one directed stimulus row; has_exp marks rows with a typed-in result
    typedef struct {
        logic        cmd;
        logic [2:0]  voice;
        t_note       note;
        logic        has_exp;
        t_beat_out   exp;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata = '0;
    logic [0:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [23:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    five_voice_chiptune_synth_unit #(.FIFO_DEPTH(DEPTH)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #200ms;
        $display("status: fail");
        $finish;
    end

    // ---------------------------------------------------------------- model
    t_note       note_q   [NUM_VOICES][DEPTH];
    int unsigned note_cnt [NUM_VOICES];
    int unsigned rd_idx   [NUM_VOICES];
    int unsigned wr_idx   [NUM_VOICES];
    bit          playing  [NUM_VOICES];
    logic [31:0] step_now [NUM_VOICES];
    logic [31:0] sweep_now[NUM_VOICES];
    logic [23:0] left_now [NUM_VOICES];
    logic [23:0] len_now  [NUM_VOICES];
    logic [23:0] atk_now  [NUM_VOICES];
    logic [23:0] rel_now  [NUM_VOICES];
    logic [15:0] vol_now  [NUM_VOICES];
    logic [31:0] phase    [NUM_VOICES];
    int          noise_out;
    logic [22:0] lfsr;

    t_beat_out   beats_due[$];
    int          n_err;
    int          n_ticks, n_drops;

    function automatic void synth_reset();
        for (int v = 0; v < NUM_VOICES; v++) begin
            note_cnt[v] = 0; rd_idx[v] = 0; wr_idx[v] = 0; playing[v] = 0;
            phase[v] = '0;
        end
        noise_out = 0;
        lfsr = 23'd1;
    endfunction

    function automatic void take_note(int v);
        t_note n;
        n = note_q[v][rd_idx[v]];
        step_now[v] = {n.step, 8'd0};
        sweep_now[v] = n.sweep;
        len_now[v] = n.length;
        left_now[v] = n.length;
        atk_now[v] = n.attack;
        rel_now[v] = n.release_n;
        vol_now[v] = n.volume;
        rd_idx[v] = (rd_idx[v] + 1) % DEPTH;
        note_cnt[v]--;
    endfunction

    function automatic int apply_gain(int w, longint unsigned g);
        longint p;
        p = longint'(w) * longint'(g);
        return int'((p + 64'sd2147483648) >>> 16) - 32768;
    endfunction

    function automatic logic [15:0] draw_noise();
        for (int k = 0; k < 16; k++)
            lfsr = {lfsr[21:0], lfsr[22] ^ lfsr[17]};
        return lfsr[15:0];
    endfunction

    function automatic t_beat_out synth_step(logic cmd, logic [2:0] voice, t_note n);
        t_beat_out r;
        int mix;
        longint unsigned a, rr, g, el, nd;
        longint ns;
        logic [31:0] ph, d;
        int w;
        r = '{sample: '0, tick: 1'b0, dropped: 1'b0};
        if (cmd == CMD_ENQUEUE) begin
            if (voice < NUM_VOICES) begin
                if (note_cnt[voice] >= DEPTH) r.dropped = 1'b1;
                else begin
                    note_q[voice][wr_idx[voice]] = n;
                    wr_idx[voice] = (wr_idx[voice] + 1) % DEPTH;
                    note_cnt[voice]++;
                end
            end
            return r;
        end
        mix = 0;
        for (int v = 0; v < NUM_VOICES; v++) begin
            if (!playing[v]) begin
                if (note_cnt[v] == 0) continue;
                take_note(v);
                playing[v] = 1;
            end
            if (left_now[v] == 0) begin
                if (note_cnt[v] != 0) take_note(v);
                else playing[v] = 0;
            end
            if (!playing[v]) continue;
            el = 64'(len_now[v] - left_now[v]);
            if (atk_now[v] == 0 || el >= atk_now[v]) a = 65536;
            else a = (el << 16) / atk_now[v];
            if (left_now[v] < rel_now[v]) rr = (64'(left_now[v]) << 16) / rel_now[v];
            else rr = 65536;
            g = (((64'(vol_now[v]) * a) >> 16) * rr) >> 16;
            ph = phase[v];
            if (v <= VOICE_PULSE_B) begin
                w = (ph <= 32'h2000_0000) ? 32768 : -32768;
                mix += apply_gain(w, g);
                phase[v] = ph + step_now[v];
            end else if (v == VOICE_TRI) begin
                d = (ph >= 32'h8000_0000) ? ph - 32'h8000_0000 : 32'h8000_0000 - ph;
                w = 32768 - int'(d >> 15);
                mix += apply_gain(w, g);
                phase[v] = ph + step_now[v];
            end else if (v == VOICE_SAW) begin
                w = int'((ph - 32'h8000_0000) >> 16) - 32768;
                mix += apply_gain(w, g);
                phase[v] = ph + step_now[v];
            end else begin
                if (step_now[v] == 0) phase[v] = '0;
                else begin
                    nd = (64'(ph) + 64'h10000) % step_now[v];
                    if (64'(ph) > nd) noise_out = apply_gain(int'(draw_noise()) - 32768, g);
                    phase[v] = nd[31:0];
                end
                mix += noise_out;
            end
            if (left_now[v] != 0) left_now[v]--;
            ns = longint'(step_now[v]) + longint'($signed(sweep_now[v]));
            if (ns < 0) ns = 0;
            if (ns > 64'sd4294967295) ns = 64'sd4294967295;
            step_now[v] = ns[31:0];
        end
        r.sample = mix[18:0];
        r.tick = 1'b1;
        return r;
    endfunction

    // ---------------------------------------------------------------- check
    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_err++;
    endtask

    bit quiet_out;   // no output stalls in the last part

    // output side: random stall bursts, compare each accepted beat
    initial begin
        int hold;
        t_beat_out e;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!quiet_out && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                hold = $urandom_range(1, 9);
                repeat (hold) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                if (beats_due.size() == 0) begin
                    report_mismatch("unexpected output beat", 1, 0);
                end else begin
                    e = beats_due.pop_front();
                    if (m_axis_tdata[18:0] !== e.sample)
                        report_mismatch("mixed_sample", $signed(m_axis_tdata[18:0]),
                                        $signed(e.sample));
                    if (m_axis_tdata[23:19] !== 5'd0)
                        report_mismatch("tdata pad", m_axis_tdata[23:19], 0);
                    if (m_axis_tuser[0] !== e.tick)
                        report_mismatch("sample_valid", m_axis_tuser[0], e.tick);
                    if (m_axis_tuser[1] !== e.dropped)
                        report_mismatch("enqueue_dropped", m_axis_tuser[1], e.dropped);
                end
            end
        end
    end

    // ---------------------------------------------------------------- drive
    bit quiet_in;

    // send one beat, predict it and queue the expectation
    task automatic send_beat(logic cmd, logic [2:0] voice, t_note n,
                             bit has_exp = 0, t_beat_out exp = '{0, 0, 0});
        t_beat_out p;
        if (!quiet_in && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tdata <= {5'd0, n.volume, n.release_n, n.attack, n.length,
                         n.sweep, n.step, voice};
        s_axis_tuser <= cmd;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        p = synth_step(cmd, voice, n);
        if (has_exp && p != exp)
            report_mismatch("directed row", int'(p), int'(exp));
        beats_due.push_back(p);
        if (cmd == CMD_TICK) n_ticks++;
        if (p.dropped) n_drops++;
    endtask

    function automatic t_note mk(logic [23:0] st, logic [31:0] sw, logic [23:0] ln,
                                 logic [23:0] at, logic [23:0] rl, logic [15:0] vo);
        t_note n;
        n.step = st; n.sweep = sw; n.length = ln;
        n.attack = at; n.release_n = rl; n.volume = vo;
        return n;
    endfunction

    // small lengths most of the time so notes turn over often
    function automatic t_note rand_note();
        t_note n;
        n = mk(24'($urandom), $urandom, 24'($urandom_range(1, 40)),
               24'($urandom_range(0, 30)), 24'($urandom_range(0, 30)), 16'($urandom));
        case ($urandom_range(0, 9))
            0: n.length = 24'($urandom);
            1: n.length = '0;
            2: begin n.attack = 24'($urandom); n.release_n = 24'($urandom); end
            3: n.volume = 16'hFFFF;
            4: n.step = 24'($urandom_range(0, 3));
            5: n.sweep = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: ;
        endcase
        return n;
    endfunction

    t_row rows[$];
    localparam t_beat_out ENQ_OK  = '{19'd0, 1'b0, 1'b0};
    localparam t_beat_out ENQ_DRP = '{19'd0, 1'b0, 1'b1};
    localparam t_beat_out SILENT  = '{19'd0, 1'b1, 1'b0};

    initial begin
        t_note z, fl;
        n_err = 0; n_ticks = 0; n_drops = 0;
        quiet_in = 0; quiet_out = 0;
        synth_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        z  = mk(0, 0, 1, 0, 0, 0);
        fl = mk(24'hFFFFFF, 32'hFFFF_FFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
        // tick after reset is silent
        rows.push_back('{CMD_TICK, VOICE_NOISE, z, 1, SILENT});
        // voice out of range is ignored without drop
        rows.push_back('{CMD_ENQUEUE, 3'd7, fl, 1, ENQ_OK});
        rows.push_back('{CMD_ENQUEUE, 3'd5, fl, 1, ENQ_OK});
        // fill pulse A, then overflow is reported
        for (int k = 0; k < DEPTH; k++)
            rows.push_back('{CMD_ENQUEUE, VOICE_PULSE_A,
                             mk(24'h200000, 32'h8000_0000, 2, 0, 1, 16'hFFFF), 1, ENQ_OK});
        rows.push_back('{CMD_ENQUEUE, VOICE_PULSE_A, fl, 1, ENQ_DRP});
        // zero length note, full-scale and max sweep notes on pulse B, triangle and saw
        rows.push_back('{CMD_ENQUEUE, VOICE_PULSE_B, mk(0, 0, 0, 0, 0, 16'hFFFF), 1, ENQ_OK});
        rows.push_back('{CMD_ENQUEUE, VOICE_PULSE_B, fl, 1, ENQ_OK});
        rows.push_back('{CMD_ENQUEUE, VOICE_TRI, mk(24'h123456, 32'h7FFF_FFFF, 3, 2, 2,
                                                    16'hFFFF), 1, ENQ_OK});
        rows.push_back('{CMD_ENQUEUE, VOICE_TRI, mk(24'hFFFFFF, 0, 1, 0, 0, 16'h8000), 1, ENQ_OK});
        rows.push_back('{CMD_ENQUEUE, VOICE_SAW, fl, 1, ENQ_OK});
        // noise with period zero, then a short period
        rows.push_back('{CMD_ENQUEUE, VOICE_NOISE, mk(0, 0, 2, 0, 0, 16'hFFFF), 1, ENQ_OK});
        rows.push_back('{CMD_ENQUEUE, VOICE_NOISE, mk(24'h000180, 32'hFFFF_FF00, 6, 1, 3,
                                                      16'hFFFF), 1, ENQ_OK});
        for (int k = 0; k < 6; k++)
            rows.push_back('{CMD_TICK, 3'($urandom), z, 0, SILENT});

        foreach (rows[i])
            send_beat(rows[i].cmd, rows[i].voice, rows[i].note,
                      rows[i].has_exp, rows[i].exp);

        // random part: mostly enqueue/tick mixes, some invalid voices
        for (int i = 0; i < 1200; i++) begin
            if (i == 1000) begin quiet_in = 1; quiet_out = 1; end
            if ($urandom_range(0, 2) == 0)
                send_beat(CMD_TICK, 3'($urandom), rand_note());
            else if ($urandom_range(0, 19) == 0)
                send_beat(CMD_ENQUEUE, 3'($urandom_range(5, 7)), rand_note());
            else
                send_beat(CMD_ENQUEUE, 3'($urandom_range(0, 4)), rand_note());
        end
        s_axis_tvalid <= 1'b0;

        fork
            wait (beats_due.size() == 0);
            begin
                repeat (200000) @(posedge i_clk);
                $display("status: fail");
                $finish;
            end
        join_any
        repeat (400) @(posedge i_clk);
        $display("run covered %0d input beats: %0d sample ticks, %0d dropped enqueues",
                 rows.size() + 1200, n_ticks, n_drops);
        if (n_err == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
